// ===== rtl/eeg_pkg.sv =====
// package for the extended euclid gcd block: sequencer state type
`timescale 1ns / 1ps
`default_nettype none

package eeg_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_UPDATE
	} eeg_state_t;

endpackage

`default_nettype wire

// ===== rtl/extended_euclid_gcd.sv =====
// extended euclidean gcd: iterative divider with shift-and-add coefficient update
//
// Request: pulse start while busy is low; operand_a and operand_b are taken at
// that edge and busy rises on the next cycle. The block returns gcd_value and
// the signed Bezout coefficients coeff_a, coeff_b, with
// operand_a*coeff_a + operand_b*coeff_b == gcd_value.
// The result is written to the output ports with done high for a single cycle;
// the receiver must take it then, it cannot stall the block.
// Timing: one restoring divider step per cycle. Each Euclid iteration runs one
// zero check, WIDTH divide steps and one update; the quotient times coefficient
// products are built bit by bit alongside the divide. An item runs k iterations,
// where k is at most about 1.44*WIDTH.
// If operand_b is zero the first zero check finishes the item with no divide.
// One request is in flight at a time; a new start is taken in the cycle done
// is high.
// Reset: arst_n low clears the sequencer to idle with busy and done low.
`timescale 1ns / 1ps
`default_nettype none

module extended_euclid_gcd #(
	parameter int WIDTH = 32
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic [WIDTH-1:0]        operand_a,
	input  wire logic [WIDTH-1:0]        operand_b,
	output logic                         done,
	output logic [WIDTH-1:0]             gcd_value,
	output logic signed [WIDTH:0]        coeff_a,
	output logic signed [WIDTH:0]        coeff_b
);

	import eeg_pkg::*;

	localparam int CW = $clog2(WIDTH);

	eeg_state_t state_q, state_d;

	logic [WIDTH-1:0] prev_rem_q, cur_rem_q, part_rem_q, dvd_q;
	logic [WIDTH:0]   prev_ca_q, cur_ca_q, prev_cb_q, cur_cb_q;
	logic [WIDTH:0]   prod_a_q, prod_b_q;
	logic [CW-1:0]    count_q;
	logic             done_q;
	logic [WIDTH-1:0] gcd_q;
	logic [WIDTH:0]   res_ca_q, res_cb_q;

	logic             do_load, do_init, do_step, do_update, do_finish;
	logic             last_step;
	logic [WIDTH:0]   shifted, diff;
	logic             qbit;

	// one restoring divide step
	assign shifted   = {part_rem_q, dvd_q[WIDTH-1]};
	assign diff      = shifted - {1'b0, cur_rem_q};
	assign qbit      = ~diff[WIDTH];
	assign last_step = (count_q == CW'(WIDTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		do_load   = 1'b0;
		do_init   = 1'b0;
		do_step   = 1'b0;
		do_update = 1'b0;
		do_finish = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					do_load = 1'b1;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (cur_rem_q == '0) begin
					do_finish = 1'b1;
					state_d   = ST_IDLE;
				end else begin
					do_init = 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				do_step = 1'b1;
				if (last_step) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				do_update = 1'b1;
				state_d   = ST_CHECK;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= do_finish;
		end
	end

	always_ff @(posedge clk) begin
		if (do_load) begin
			prev_rem_q <= operand_a;
			cur_rem_q  <= operand_b;
			prev_ca_q  <= (WIDTH+1)'(1);
			cur_ca_q   <= '0;
			prev_cb_q  <= '0;
			cur_cb_q   <= (WIDTH+1)'(1);
		end
		if (do_init) begin
			part_rem_q <= '0;
			dvd_q      <= prev_rem_q;
			prod_a_q   <= '0;
			prod_b_q   <= '0;
			count_q    <= '0;
		end
		if (do_step) begin
			part_rem_q <= qbit ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
			dvd_q      <= {dvd_q[WIDTH-2:0], 1'b0};
			// quotient bits arrive msb first, so double and add
			prod_a_q   <= {prod_a_q[WIDTH-1:0], 1'b0} + (qbit ? cur_ca_q : '0);
			prod_b_q   <= {prod_b_q[WIDTH-1:0], 1'b0} + (qbit ? cur_cb_q : '0);
			count_q    <= count_q + CW'(1);
		end
		if (do_update) begin
			prev_rem_q <= cur_rem_q;
			cur_rem_q  <= part_rem_q;
			prev_ca_q  <= cur_ca_q;
			cur_ca_q   <= prev_ca_q - prod_a_q;
			prev_cb_q  <= cur_cb_q;
			cur_cb_q   <= prev_cb_q - prod_b_q;
		end
		if (do_finish) begin
			gcd_q    <= prev_rem_q;
			res_ca_q <= prev_ca_q;
			res_cb_q <= prev_cb_q;
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign gcd_value = gcd_q;
	assign coeff_a   = res_ca_q;
	assign coeff_b   = res_cb_q;

endmodule

`default_nettype wire

// ===== tb/tb_extended_euclid_gcd.sv =====
// testbench for extended_euclid_gcd: directed and random requests checked against a gcd predictor
`timescale 1ns / 1ps

localparam int OPND_W = 32;

typedef struct packed {
	logic [OPND_W-1:0] a;
	logic [OPND_W-1:0] b;
	logic [OPND_W-1:0] gcd;
	logic signed [OPND_W:0] ca;
	logic signed [OPND_W:0] cb;
} gcd_result_t;

class gcd_scoreboard;
	gcd_result_t pending[$];
	int errors = 0;

	// coefficients kept modulo 2^64, only the low bits are returned
	function gcd_result_t predict(input logic [OPND_W-1:0] a, input logic [OPND_W-1:0] b);
		logic [63:0] r0, r1, s0, s1, t0, t1, q, tmp;
		gcd_result_t res;
		r0 = 64'(a);
		r1 = 64'(b);
		s0 = 64'd1;
		s1 = 64'd0;
		t0 = 64'd0;
		t1 = 64'd1;
		while (r1 != 64'd0) begin
			q = r0 / r1;
			tmp = r0 % r1;
			r0 = r1;
			r1 = tmp;
			tmp = s0 - q * s1;
			s0 = s1;
			s1 = tmp;
			tmp = t0 - q * t1;
			t0 = t1;
			t1 = tmp;
		end
		res.a = a;
		res.b = b;
		res.gcd = r0[OPND_W-1:0];
		res.ca = s0[OPND_W:0];
		res.cb = t0[OPND_W:0];
		return res;
	endfunction

	function void note_request(input logic [OPND_W-1:0] a, input logic [OPND_W-1:0] b);
		pending.push_back(predict(a, b));
	endfunction

	function void check_result(input logic [OPND_W-1:0] g, input logic signed [OPND_W:0] ca,
			input logic signed [OPND_W:0] cb);
		gcd_result_t want;
		if (pending.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected result: gcd %0d ca %0d cb %0d", g, ca, cb);
			return;
		end
		want = pending.pop_front();
		if (g !== want.gcd || ca !== want.ca || cb !== want.cb) begin
			errors++;
			if (errors <= 10)
				$display("mismatch a=%0d b=%0d: expected %0d %0d %0d, got %0d %0d %0d",
					want.a, want.b, want.gcd, want.ca, want.cb, g, ca, cb);
		end
	endfunction
endclass

module tb_extended_euclid_gcd;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [OPND_W-1:0] operand_a;
	logic [OPND_W-1:0] operand_b;
	logic done;
	logic [OPND_W-1:0] gcd_value;
	logic signed [OPND_W:0] coeff_a;
	logic signed [OPND_W:0] coeff_b;

	gcd_scoreboard sb = new();

	extended_euclid_gcd #(.WIDTH(OPND_W)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operand_a(operand_a),
		.operand_b(operand_b),
		.done(done),
		.gcd_value(gcd_value),
		.coeff_a(coeff_a),
		.coeff_b(coeff_b)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// pre-edge values are seen here, so results and requests are taken race free
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result(gcd_value, coeff_a, coeff_b);
			if (start && !busy)
				sb.note_request(operand_a, operand_b);
		end
	end

	// called at a rising edge; returns at the edge that takes the request
	task automatic send(input logic [OPND_W-1:0] a, input logic [OPND_W-1:0] b);
		start <= 1'b1;
		operand_a <= a;
		operand_b <= b;
		do @(posedge clk); while (busy);
	endtask

	task automatic idle_after(input int idle_pct);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
	endtask

	// one edge first, so the request taken at the calling edge is already noted
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(input int count, input int idle_pct);
		logic [OPND_W-1:0] a, b, g;
		logic [63:0] f0, f1, t;
		int k;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(9))
				0, 1, 2: begin
					a = $urandom;
					b = $urandom;
				end
				3: begin
					a = $urandom_range(255);
					b = $urandom_range(255);
				end
				4: begin
					g = $urandom_range(1, 65535);
					a = g * $urandom_range(65535);
					b = g * $urandom_range(65535);
				end
				5: begin
					// consecutive fibonacci numbers give the longest runs
					f0 = 64'd0;
					f1 = 64'd1;
					k = $urandom_range(1, 46);
					repeat (k) begin
						t = f0 + f1;
						f0 = f1;
						f1 = t;
					end
					if ($urandom_range(1)) begin
						a = f1[OPND_W-1:0];
						b = f0[OPND_W-1:0];
					end else begin
						a = f0[OPND_W-1:0];
						b = f1[OPND_W-1:0];
					end
				end
				6: begin
					a = $urandom;
					b = '0;
					if ($urandom_range(1)) begin
						b = a;
						a = '0;
					end
				end
				7: begin
					a = $urandom;
					b = a + $urandom_range(2) - 1;
				end
				8: begin
					a = $urandom;
					b = $urandom_range(1, 16);
					if ($urandom_range(1)) begin
						g = a;
						a = b;
						b = g;
					end
				end
				default: begin
					a = $urandom | 32'h8000_0000;
					b = $urandom | 32'h8000_0000;
				end
			endcase
			send(a, b);
			if (i < count - 1)
				idle_after(idle_pct);
		end
		drain();
	endtask

	logic [OPND_W-1:0] dir_a[$] = '{
		32'd0, 32'd12345, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
		32'd1, 32'hFFFF_FFFF, 32'd2971215073, 32'd1836311903, 32'd12, 32'd240,
		32'd1, 32'h8000_0000, 32'h8000_0000, 32'd4294967291, 32'd7, 32'hFFFF_FFFE
	};
	logic [OPND_W-1:0] dir_b[$] = '{
		32'd0, 32'd0, 32'd67890, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd0,
		32'hFFFF_FFFF, 32'd1, 32'd1836311903, 32'd2971215073, 32'd18, 32'd46,
		32'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'd4294967279, 32'hFFFF_FFFF, 32'hFFFF_FFFF
	};

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		operand_a = '0;
		operand_b = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero operands, extremes, operand order swap, worst case fibonacci pair
		for (int i = 0; i < dir_a.size(); i++)
			send(dir_a[i], dir_b[i]);
		drain();

		run_phase(118, 18);
		run_phase(118, 69);
		run_phase(118, 0);

		repeat (2000) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== extended_euclid_gcd.f =====
rtl/eeg_pkg.sv
rtl/extended_euclid_gcd.sv
tb/tb_extended_euclid_gcd.sv
